// File: src/lnr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Layer normalization row unit package
// Shared constants, payload structures and the back end state type.
// ---------------------------------------------------------------------------
package lnr_pkg;

   localparam int MAX_ROW    = 64;
   localparam int ROOT_STEPS = 4;

   localparam int DATA_W  = 16;
   localparam int EPS_W   = 16;
   localparam int ROW_W   = $clog2(MAX_ROW);
   localparam int CNT_W   = ROW_W + 1;
   localparam int MEM_AW  = ROW_W + 1;
   localparam int SUM_W   = DATA_W + ROW_W;
   localparam int SQ_W    = 2 * DATA_W - 1 + ROW_W;
   localparam int NQ_W    = SQ_W + CNT_W;
   localparam int NN_W    = 2 * CNT_W - 1;
   localparam int CYC_W   = $clog2(NQ_W + 1);
   localparam int V_W     = 32;
   localparam int MANT_W  = 62;
   localparam int K_W     = 4;
   localparam int Y_W     = 32;
   localparam int MA_W    = 33;
   localparam int MP_W    = 65;
   localparam int STEP_W  = $clog2(ROOT_STEPS + 1);
   localparam int PH_W    = 3;
   localparam int Y20_W   = 23;
   localparam int D_W     = SUM_W + 2;
   localparam int P1_W    = D_W + DATA_W;
   localparam int MAG_W   = 64;
   localparam int QD_W    = 40;
   localparam int DIG_N   = 8;
   localparam int QD_CYC  = QD_W / DIG_N;
   localparam int O_W     = QD_W + 2;
   localparam int HALF_SH = 23;
   localparam int FULL_SH = 24;

   localparam logic [Y_W-1:0]   Y_INIT  = Y_W'(11) << 26;
   localparam logic [Y_W-1:0]   Y_MAX   = Y_W'(1) << 31;
   localparam logic [Y_W-1:0]   THREE_Q = Y_W'(3) << 30;
   localparam logic [EPS_W-1:0] EPS_RST = EPS_W'(1);

   localparam logic [PH_W-1:0] PH_SQUARE = 3'd0;
   localparam logic [PH_W-1:0] PH_MANT   = 3'd1;
   localparam logic [PH_W-1:0] PH_RESID  = 3'd2;
   localparam logic [PH_W-1:0] PH_SCALE  = 3'd3;
   localparam logic [PH_W-1:0] PH_UPDATE = 3'd4;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic [DATA_W-1:0] scale;
      logic [DATA_W-1:0] shift;
   } elem_type;

   typedef struct packed {
      logic              en;
      logic [MEM_AW-1:0] addr;
      elem_type          data;
   } mem_wr_type;

   typedef struct packed {
      logic [CNT_W-1:0]        n;
      logic signed [SUM_W-1:0] sum;
      logic [SQ_W-1:0]         sq;
      logic                    bank;
   } row_desc_type;

   typedef enum logic [3:0] {
      B_IDLE, B_PREP, B_DIFF, B_VDIV, B_VADD, B_NORM, B_ROOT, B_ROUND,
      B_READ, B_DEV, B_MUL1, B_MUL2, B_SCALE, B_QDIV, B_OUT
   } back_state_type;

endpackage
`default_nettype wire

// File: src/lnr_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Layer normalization row unit channels
// Element, result and register write channels with valid and ready.
// ---------------------------------------------------------------------------
interface lnr_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [lnr_pkg::DATA_W-1:0] value_in;
   logic signed [lnr_pkg::DATA_W-1:0] scale_in;
   logic signed [lnr_pkg::DATA_W-1:0] shift_in;
   logic                              row_end;
   modport source (output valid, value_in, scale_in, shift_in, row_end, input ready);
   modport sink (input valid, value_in, scale_in, shift_in, row_end, output ready);
endinterface

interface lnr_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [lnr_pkg::DATA_W-1:0] value_out;
   logic                              clipped;
   logic                              out_last;
   modport source (output valid, value_out, clipped, out_last, input ready);
   modport sink (input valid, value_out, clipped, out_last, output ready);
endinterface

interface lnr_csr_if;
   logic                       valid;
   logic                       ready;
   logic [lnr_pkg::EPS_W-1:0]  data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// File: src/lnr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Layer normalization front end
// Accepts element beats, writes the row buffer and accumulates statistics.
// ---------------------------------------------------------------------------
module lnr_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   lnr_req_if.sink                    req_bus,
   input  wire logic                  row_done,
   output lnr_pkg::mem_wr_type        mem_wr,
   output lnr_pkg::row_desc_type      desc,
   output logic                       desc_push
);

   logic [lnr_pkg::CNT_W-1:0]        count_ff, count_in;
   logic signed [lnr_pkg::SUM_W-1:0] sum_ff, sum_in, sum_nx;
   logic [lnr_pkg::SQ_W-1:0]         sq_ff, sq_in, sq_nx;
   logic                             bank_ff, bank_in;
   logic [1:0]                       pending_ff, pending_in;
   logic                             accept, last;
   logic signed [2*lnr_pkg::DATA_W-1:0] xx;

   assign req_bus.ready = (pending_ff != 2'd2);
   assign accept = req_bus.valid && req_bus.ready;
   assign last = req_bus.row_end || (count_ff == lnr_pkg::CNT_W'(lnr_pkg::MAX_ROW - 1));
   assign xx = req_bus.value_in * req_bus.value_in;
   assign sum_nx = sum_ff + lnr_pkg::SUM_W'(req_bus.value_in);
   assign sq_nx = sq_ff + lnr_pkg::SQ_W'(xx[2*lnr_pkg::DATA_W-2:0]);

   assign mem_wr.en = accept;
   assign mem_wr.addr = {bank_ff, count_ff[lnr_pkg::ROW_W-1:0]};
   assign mem_wr.data = {req_bus.value_in, req_bus.scale_in, req_bus.shift_in};

   assign desc.n = count_ff + lnr_pkg::CNT_W'(1);
   assign desc.sum = sum_nx;
   assign desc.sq = sq_nx;
   assign desc.bank = bank_ff;
   assign desc_push = accept && last;

   always_comb begin
      count_in = count_ff;
      sum_in = sum_ff;
      sq_in = sq_ff;
      bank_in = bank_ff;
      if (desc_push) begin
         count_in = '0;
         sum_in = '0;
         sq_in = '0;
         bank_in = !bank_ff;
      end else if (accept) begin
         count_in = count_ff + lnr_pkg::CNT_W'(1);
         sum_in = sum_nx;
         sq_in = sq_nx;
      end
      pending_in = pending_ff + 2'(desc_push) - 2'(row_done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff <= '0;
         sq_ff <= '0;
         bank_ff <= 1'b0;
         pending_ff <= '0;
      end else begin
         count_ff <= count_in;
         sum_ff <= sum_in;
         sq_ff <= sq_in;
         bank_ff <= bank_in;
         pending_ff <= pending_in;
      end
   end

endmodule
`default_nettype wire

// File: src/lnr_row_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Layer normalization row queue
// Two-entry queue of finished row descriptors between front and back.
// ---------------------------------------------------------------------------
module lnr_row_fifo (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  lnr_pkg::row_desc_type      push_data,
   input  wire logic                  pop,
   output logic                       head_valid,
   output lnr_pkg::row_desc_type      head_data
);

   lnr_pkg::row_desc_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign head_valid = (fill_ff != 2'd0);
   assign head_data = entry_ff[rd_ptr_ff];
   assign do_push = push && (fill_ff != 2'd2);
   assign do_pop = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in = fill_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

endmodule
`default_nettype wire

// File: src/lnr_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Layer normalization back end
// Variance divide, inverse square root and per-element normalization.
// ---------------------------------------------------------------------------
module lnr_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   lnr_rsp_if.source                  rsp_bus,
   lnr_csr_if.sink                    csr_bus,
   input  lnr_pkg::mem_wr_type        mem_wr,
   input  wire logic                  desc_valid,
   input  lnr_pkg::row_desc_type      desc,
   output logic                       desc_pop,
   output logic                       row_done
);

   lnr_pkg::elem_type row_mem [2**lnr_pkg::MEM_AW];
   lnr_pkg::elem_type rd_data_ff;
   logic [lnr_pkg::MEM_AW-1:0] rd_addr;

   lnr_pkg::back_state_type state_ff, state_in;

   logic [lnr_pkg::EPS_W-1:0]        eps_ff;
   logic [lnr_pkg::CNT_W-1:0]        n_ff;
   logic signed [lnr_pkg::SUM_W-1:0] sum_ff;
   logic [lnr_pkg::SQ_W-1:0]         sq_ff;
   logic                             bank_ff;
   logic [lnr_pkg::NQ_W-1:0]         nq_ff, ssq_ff, dq_ff;
   logic [lnr_pkg::NN_W-1:0]         nn_ff, rem_ff;
   logic [lnr_pkg::CYC_W-1:0]        cnt_ff;
   logic [lnr_pkg::MANT_W-1:0]       mant_ff;
   logic [lnr_pkg::K_W-1:0]          k_ff;
   logic [lnr_pkg::Y_W-1:0]          y_ff, r_ff;
   logic [lnr_pkg::MP_W-1:0]         prod_ff;
   logic [lnr_pkg::PH_W-1:0]         phase_ff;
   logic [lnr_pkg::STEP_W-1:0]       step_ff;
   logic [lnr_pkg::Y20_W-1:0]        y20_ff;
   logic [lnr_pkg::CNT_W-1:0]        idx_ff;
   logic signed [lnr_pkg::D_W-1:0]   d_ff;
   logic signed [lnr_pkg::DATA_W-1:0] sc_ff, sh_ff;
   logic                             neg_ff;
   logic [lnr_pkg::P1_W-1:0]         p1_ff;
   logic [lnr_pkg::MAG_W-1:0]        mag_ff;
   logic [lnr_pkg::QD_W-1:0]         qd_ff;
   logic [lnr_pkg::CNT_W-1:0]        erem_ff;
   logic                             out_valid_ff, out_valid_in;
   logic signed [lnr_pkg::DATA_W-1:0] out_value_ff;
   logic                             out_clip_ff, out_last_ff;

   logic                             load_out, last_elem, root_done;
   logic [lnr_pkg::SUM_W-1:0]        s_abs;
   logic [lnr_pkg::NN_W:0]           vrem_sh;
   logic                             vge;
   logic [lnr_pkg::V_W:0]            v_sum;
   logic [lnr_pkg::V_W-1:0]          v_val;
   logic [lnr_pkg::Y_W-1:0]          y_clamp;
   logic [lnr_pkg::MA_W-1:0]         mul_a;
   logic [lnr_pkg::Y_W-1:0]          mul_b;
   logic [lnr_pkg::MP_W-1:0]         mul_p;
   logic [lnr_pkg::MP_W-31:0]        t_val;
   logic [lnr_pkg::Y_W:0]            y_rnd;
   logic signed [lnr_pkg::DATA_W-1:0] x_val;
   logic signed [lnr_pkg::D_W-1:0]   d_val;
   logic [lnr_pkg::D_W-1:0]          d_abs;
   logic [lnr_pkg::DATA_W-1:0]       sc_abs;
   logic [lnr_pkg::MAG_W-1:0]        rnd_add, scaled;
   logic [lnr_pkg::CNT_W-1:0]        erem_nx;
   logic [lnr_pkg::QD_W-1:0]         qd_nx;
   logic [lnr_pkg::CNT_W:0]          etry;
   logic signed [lnr_pkg::O_W-1:0]   q_signed, o_val;
   logic signed [lnr_pkg::DATA_W-1:0] o_sat;
   logic                             o_clip;

   assign rd_addr = {bank_ff, idx_ff[lnr_pkg::ROW_W-1:0]};

   always_ff @(posedge clock) begin
      if (mem_wr.en) begin
         row_mem[mem_wr.addr] <= mem_wr.data;
      end
      rd_data_ff <= row_mem[rd_addr];
   end

   assign csr_bus.ready = 1'b1;
   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.value_out = out_value_ff;
   assign rsp_bus.clipped = out_clip_ff;
   assign rsp_bus.out_last = out_last_ff;

   assign last_elem = (idx_ff == n_ff - lnr_pkg::CNT_W'(1));
   assign root_done = (phase_ff == lnr_pkg::PH_UPDATE)
                      && (step_ff == lnr_pkg::STEP_W'(lnr_pkg::ROOT_STEPS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lnr_pkg::B_IDLE: begin
            if (desc_valid) state_in = lnr_pkg::B_PREP;
         end
         lnr_pkg::B_PREP: state_in = lnr_pkg::B_DIFF;
         lnr_pkg::B_DIFF: state_in = lnr_pkg::B_VDIV;
         lnr_pkg::B_VDIV: begin
            if (cnt_ff == lnr_pkg::CYC_W'(lnr_pkg::NQ_W - 1)) state_in = lnr_pkg::B_VADD;
         end
         lnr_pkg::B_VADD: state_in = lnr_pkg::B_NORM;
         lnr_pkg::B_NORM: begin
            if (mant_ff[lnr_pkg::MANT_W-1:lnr_pkg::V_W] == '0) state_in = lnr_pkg::B_ROOT;
         end
         lnr_pkg::B_ROOT: begin
            if (root_done) state_in = lnr_pkg::B_ROUND;
         end
         lnr_pkg::B_ROUND: state_in = lnr_pkg::B_READ;
         lnr_pkg::B_READ: state_in = lnr_pkg::B_DEV;
         lnr_pkg::B_DEV: state_in = lnr_pkg::B_MUL1;
         lnr_pkg::B_MUL1: state_in = lnr_pkg::B_MUL2;
         lnr_pkg::B_MUL2: state_in = lnr_pkg::B_SCALE;
         lnr_pkg::B_SCALE: state_in = lnr_pkg::B_QDIV;
         lnr_pkg::B_QDIV: begin
            if (cnt_ff == lnr_pkg::CYC_W'(lnr_pkg::QD_CYC - 1)) state_in = lnr_pkg::B_OUT;
         end
         lnr_pkg::B_OUT: begin
            if (load_out) state_in = last_elem ? lnr_pkg::B_IDLE : lnr_pkg::B_READ;
         end
         default: state_in = lnr_pkg::B_IDLE;
      endcase
   end

   always_comb begin
      desc_pop = (state_ff == lnr_pkg::B_IDLE) && desc_valid;
      load_out = (state_ff == lnr_pkg::B_OUT) && (!out_valid_ff || rsp_bus.ready);
      row_done = load_out && last_elem;
      out_valid_in = load_out || (out_valid_ff && !rsp_bus.ready);
   end

   always_comb begin
      s_abs = sum_ff[lnr_pkg::SUM_W-1] ? lnr_pkg::SUM_W'(-sum_ff) : lnr_pkg::SUM_W'(sum_ff);
      vrem_sh = {rem_ff, dq_ff[lnr_pkg::NQ_W-1]};
      vge = (vrem_sh >= {1'b0, nn_ff});
      v_sum = {1'b0, dq_ff[lnr_pkg::V_W-1:0]} + (lnr_pkg::V_W+1)'(eps_ff);
      v_val = (v_sum[lnr_pkg::V_W-1:0] == '0) ? lnr_pkg::V_W'(1) : v_sum[lnr_pkg::V_W-1:0];
      y_clamp = (y_ff > lnr_pkg::Y_MAX) ? lnr_pkg::Y_MAX : y_ff;
      t_val = prod_ff[lnr_pkg::MP_W-1:30];
      case (phase_ff)
         lnr_pkg::PH_SQUARE: begin
            mul_a = {1'b0, y_clamp};
            mul_b = y_clamp;
         end
         lnr_pkg::PH_MANT: begin
            mul_a = prod_ff[62:30];
            mul_b = mant_ff[lnr_pkg::V_W-1:0];
         end
         lnr_pkg::PH_SCALE: begin
            mul_a = {1'b0, y_ff};
            mul_b = r_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = lnr_pkg::MP_W'(mul_a) * lnr_pkg::MP_W'(mul_b);
      y_rnd = {1'b0, y_ff} + (lnr_pkg::Y_W+1)'(512);
      x_val = rd_data_ff.value;
      d_val = lnr_pkg::D_W'($signed({1'b0, n_ff})) * lnr_pkg::D_W'(x_val)
              - lnr_pkg::D_W'(sum_ff);
      d_abs = d_ff[lnr_pkg::D_W-1] ? lnr_pkg::D_W'(-d_ff) : lnr_pkg::D_W'(d_ff);
      sc_abs = sc_ff[lnr_pkg::DATA_W-1] ? lnr_pkg::DATA_W'(-sc_ff) : lnr_pkg::DATA_W'(sc_ff);
      rnd_add = mag_ff + (lnr_pkg::MAG_W'(n_ff) << (lnr_pkg::HALF_SH + int'(k_ff)));
      scaled = rnd_add >> (lnr_pkg::FULL_SH + int'(k_ff));
      erem_nx = erem_ff;
      qd_nx = qd_ff;
      for (int i = 0; i < lnr_pkg::DIG_N; i++) begin
         etry = {erem_nx, qd_nx[lnr_pkg::QD_W-1]};
         qd_nx = {qd_nx[lnr_pkg::QD_W-2:0], 1'b0};
         if (etry >= {1'b0, n_ff}) begin
            etry = etry - {1'b0, n_ff};
            qd_nx[0] = 1'b1;
         end
         erem_nx = etry[lnr_pkg::CNT_W-1:0];
      end
      q_signed = neg_ff ? -$signed({2'b00, qd_ff}) : $signed({2'b00, qd_ff});
      o_val = q_signed + lnr_pkg::O_W'(sh_ff);
      o_clip = 1'b1;
      if (o_val > lnr_pkg::O_W'(32767)) begin
         o_sat = 16'sh7FFF;
      end else if (o_val < -lnr_pkg::O_W'(32768)) begin
         o_sat = 16'sh8000;
      end else begin
         o_sat = o_val[lnr_pkg::DATA_W-1:0];
         o_clip = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         lnr_pkg::B_IDLE: begin
            n_ff <= desc.n;
            sum_ff <= desc.sum;
            sq_ff <= desc.sq;
            bank_ff <= desc.bank;
         end
         lnr_pkg::B_PREP: begin
            nq_ff <= lnr_pkg::NQ_W'(n_ff) * lnr_pkg::NQ_W'(sq_ff);
            ssq_ff <= lnr_pkg::NQ_W'(s_abs) * lnr_pkg::NQ_W'(s_abs);
            nn_ff <= lnr_pkg::NN_W'(n_ff) * lnr_pkg::NN_W'(n_ff);
         end
         lnr_pkg::B_DIFF: begin
            dq_ff <= (nq_ff > ssq_ff) ? nq_ff - ssq_ff : '0;
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         lnr_pkg::B_VDIV: begin
            dq_ff <= {dq_ff[lnr_pkg::NQ_W-2:0], vge};
            rem_ff <= vge ? lnr_pkg::NN_W'(vrem_sh - {1'b0, nn_ff})
                          : vrem_sh[lnr_pkg::NN_W-1:0];
            cnt_ff <= cnt_ff + lnr_pkg::CYC_W'(1);
         end
         lnr_pkg::B_VADD: begin
            mant_ff <= {v_val, 30'b0};
            k_ff <= '0;
         end
         lnr_pkg::B_NORM: begin
            if (mant_ff[lnr_pkg::MANT_W-1:lnr_pkg::V_W] != '0) begin
               mant_ff <= mant_ff >> 2;
               k_ff <= k_ff + lnr_pkg::K_W'(1);
            end else begin
               y_ff <= lnr_pkg::Y_INIT;
               phase_ff <= lnr_pkg::PH_SQUARE;
               step_ff <= '0;
            end
         end
         lnr_pkg::B_ROOT: begin
            case (phase_ff)
               lnr_pkg::PH_SQUARE: begin
                  y_ff <= y_clamp;
                  prod_ff <= mul_p;
                  phase_ff <= lnr_pkg::PH_MANT;
               end
               lnr_pkg::PH_MANT: begin
                  prod_ff <= mul_p;
                  phase_ff <= lnr_pkg::PH_RESID;
               end
               lnr_pkg::PH_RESID: begin
                  r_ff <= (t_val < (lnr_pkg::MP_W-30)'(lnr_pkg::THREE_Q))
                          ? lnr_pkg::Y_W'((lnr_pkg::MP_W-30)'(lnr_pkg::THREE_Q) - t_val)
                          : '0;
                  phase_ff <= lnr_pkg::PH_SCALE;
               end
               lnr_pkg::PH_SCALE: begin
                  prod_ff <= mul_p;
                  phase_ff <= lnr_pkg::PH_UPDATE;
               end
               default: begin
                  y_ff <= prod_ff[62:31];
                  step_ff <= step_ff + lnr_pkg::STEP_W'(1);
                  phase_ff <= lnr_pkg::PH_SQUARE;
               end
            endcase
         end
         lnr_pkg::B_ROUND: begin
            y20_ff <= y_rnd[lnr_pkg::Y_W:10];
            idx_ff <= '0;
         end
         lnr_pkg::B_DEV: begin
            d_ff <= d_val;
            sc_ff <= rd_data_ff.scale;
            sh_ff <= rd_data_ff.shift;
         end
         lnr_pkg::B_MUL1: begin
            p1_ff <= lnr_pkg::P1_W'(d_abs) * lnr_pkg::P1_W'(sc_abs);
            neg_ff <= d_ff[lnr_pkg::D_W-1] ^ sc_ff[lnr_pkg::DATA_W-1];
         end
         lnr_pkg::B_MUL2: begin
            mag_ff <= lnr_pkg::MAG_W'(p1_ff) * lnr_pkg::MAG_W'(y20_ff);
         end
         lnr_pkg::B_SCALE: begin
            qd_ff <= scaled[lnr_pkg::QD_W-1:0];
            erem_ff <= '0;
            cnt_ff <= '0;
         end
         lnr_pkg::B_QDIV: begin
            qd_ff <= qd_nx;
            erem_ff <= erem_nx;
            cnt_ff <= cnt_ff + lnr_pkg::CYC_W'(1);
         end
         lnr_pkg::B_OUT: begin
            if (load_out) begin
               out_value_ff <= o_sat;
               out_clip_ff <= o_clip;
               out_last_ff <= last_elem;
               idx_ff <= idx_ff + lnr_pkg::CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lnr_pkg::B_IDLE;
         out_valid_ff <= 1'b0;
         eps_ff <= lnr_pkg::EPS_RST;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
         if (csr_bus.valid && csr_bus.ready) begin
            eps_ff <= csr_bus.data;
         end
      end
   end

`ifndef SYNTHESIS
   ap_idx_in_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lnr_pkg::B_OUT) |-> (idx_ff < n_ff))
      else $error("Element index ran past the row length.");

   ap_var_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lnr_pkg::B_VADD) |-> (dq_ff[lnr_pkg::NQ_W-1:lnr_pkg::V_W-1] == '0))
      else $error("Variance quotient exceeds its range.");

   ap_root_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lnr_pkg::B_ROOT && phase_ff == lnr_pkg::PH_UPDATE)
      |-> (prod_ff[lnr_pkg::MP_W-1:63] == '0))
      else $error("Newton update overflowed the estimate width.");

   ap_done_pop: assert property (@(posedge clock) disable iff (reset)
      row_done |=> (state_ff == lnr_pkg::B_IDLE))
      else $error("Back end did not return to idle after a row.");
`endif

endmodule
`default_nettype wire

// File: src/layer_norm_row_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// The root search first shifts the variance down by k steps of two bits each,
// where k (0 to 15) is half the bit position of the leading one of the variance.
// The front end takes one element beat per cycle while fewer than two rows await output;
// the back end ends each element's multiply chain and divide by n before the next.
// Two row buffers let the next row fill while the previous one is emitted.
// Reset is synchronous and active high; it empties the queue and sets epsilon to 1.
// ---------------------------------------------------------------------------
// Layer normalization row unit
// Top level joining the front end, the row queue and the back end.
// ---------------------------------------------------------------------------
module layer_norm_row_unit (
   input  wire logic clock,
   input  wire logic reset,
   lnr_req_if.sink   req_bus,
   lnr_rsp_if.source rsp_bus,
   lnr_csr_if.sink   csr_bus
);

   lnr_pkg::mem_wr_type   mem_wr;
   lnr_pkg::row_desc_type push_desc, head_desc;
   logic                  desc_push, desc_pop, head_valid, row_done;

   lnr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .row_done  (row_done),
      .mem_wr    (mem_wr),
      .desc      (push_desc),
      .desc_push (desc_push)
   );

   lnr_row_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (desc_push),
      .push_data  (push_desc),
      .pop        (desc_pop),
      .head_valid (head_valid),
      .head_data  (head_desc)
   );

   lnr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .rsp_bus    (rsp_bus),
      .csr_bus    (csr_bus),
      .mem_wr     (mem_wr),
      .desc_valid (head_valid),
      .desc       (head_desc),
      .desc_pop   (desc_pop),
      .row_done   (row_done)
   );

endmodule
`default_nettype wire
